/* sv/halfpel_motion_compensation_assert.svh */
// Assertion macros for the half-pel motion compensation block.
// Used by halfpel_motion_compensation.sv; needs i_clk and i_rst_n in scope.
`ifndef HALFPEL_MOTION_COMPENSATION_ASSERT_SVH
`define HALFPEL_MOTION_COMPENSATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define HPMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hpmc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HPMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hpmc: next-cycle check failed");

`else

`define HPMC_ASSERT_IMP(label, ante, cons)
`define HPMC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/hpmc_pkg.sv */
// Package for the half-pel motion compensation block.
// Holds block sizes, field widths and configuration register indexes.
`timescale 1ns / 1ps

package hpmc_pkg;

    // Block and window geometry.
    localparam int MAX_BLOCK   = 16;
    localparam int CHROMA_SIZE = 8;
    localparam int ROW_DEPTH   = MAX_BLOCK + 1;
    localparam int COL_W       = $clog2(ROW_DEPTH);
    localparam int PIX_W       = 8;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HALF_X      = 2'd0,
        CFG_HALF_Y      = 2'd1,
        CFG_AVERAGE     = 2'd2,
        CFG_CHROMA      = 2'd3
    } t_cfg_idx;

endpackage

/* sv/halfpel_motion_compensation.sv */
// Half-pel motion compensation, one result register: one reference pixel per clock
// unless the output stalls. A result word reaches the master side in the cycle after
// its input is accepted; the line buffer is read one column ahead of the stream.
// Reset (synchronous, active low) clears configuration, counters, neighbor pixels and the
// line buffer valid bits; an entry never written reads as zero. No clearing pass is needed.
`timescale 1ns / 1ps

module halfpel_motion_compensation
    import hpmc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic                 i_cfg_data,
    // Slave side.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*PIX_W-1:0]   s_axis_tdata,   // [7:0] src_pixel, [15:8] prior_pixel
    // Master side.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] pred_pixel
    output logic                 m_axis_tlast    // last
);

    // Configuration registers.
    logic r_half_x, r_half_y, r_average, r_chroma;

    // Stream position and neighbor pixels.
    logic [COL_W-1:0] r_col, n_col;
    logic [COL_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_left, r_upper_left;

    // Line buffer with one valid bit per column.
    logic [PIX_W-1:0]     r_line_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] r_line_vld;
    logic [PIX_W-1:0]     r_above_raw;
    logic                 r_above_vld;

    // Output register.
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    logic             w_accept;
    logic [PIX_W-1:0] w_src, w_prior, w_above;
    logic [COL_W:0]   w_width, w_height;
    logic             w_end_col, w_end_row, w_emit;
    logic [PIX_W+1:0] w_sum;
    logic [PIX_W-1:0] w_interp;
    logic [PIX_W:0]   w_avg_sum;
    logic [PIX_W-1:0] w_pred;

    assign w_src   = s_axis_tdata[PIX_W-1:0];
    assign w_prior = s_axis_tdata[2*PIX_W-1:PIX_W];

    // The output register frees up whenever its word is taken.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Window size and position flags for the current pixel.
    always_comb begin
        w_width   = (COL_W+1)'(r_chroma ? CHROMA_SIZE : MAX_BLOCK) + (COL_W+1)'(r_half_x);
        w_height  = (COL_W+1)'(r_chroma ? CHROMA_SIZE : MAX_BLOCK) + (COL_W+1)'(r_half_y);
        w_end_col = ({1'b0, r_col} + (COL_W+1)'(1)) >= w_width;
        w_end_row = ({1'b0, r_row} + (COL_W+1)'(1)) >= w_height;
        w_emit    = (r_col >= COL_W'(r_half_x)) && (r_row >= COL_W'(r_half_y));
    end

    // Next column and row; the line buffer is read at the next column.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_end_col) begin
                n_col = '0;
                n_row = w_end_row ? '0 : r_row + COL_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Interpolation and optional averaging with the prior destination pixel.
    always_comb begin
        w_above = r_above_vld ? r_above_raw : '0;
        w_sum   = '0;
        if (r_half_x && r_half_y) begin
            w_sum    = (PIX_W+2)'(r_upper_left) + (PIX_W+2)'(w_above) + (PIX_W+2)'(r_left)
                     + (PIX_W+2)'(w_src) + (PIX_W+2)'(2);
            w_interp = w_sum[PIX_W+1:2];
        end else if (r_half_x) begin
            w_sum    = (PIX_W+2)'(r_left) + (PIX_W+2)'(w_src) + (PIX_W+2)'(1);
            w_interp = w_sum[PIX_W:1];
        end else if (r_half_y) begin
            w_sum    = (PIX_W+2)'(w_above) + (PIX_W+2)'(w_src) + (PIX_W+2)'(1);
            w_interp = w_sum[PIX_W:1];
        end else begin
            w_interp = w_src;
        end
        w_avg_sum = (PIX_W+1)'(w_interp) + (PIX_W+1)'(w_prior) + (PIX_W+1)'(1);
        w_pred    = r_average ? w_avg_sum[PIX_W:1] : w_interp;
    end

    // Configuration, counters, valid bits and output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_x     <= 1'b0;
            r_half_y     <= 1'b0;
            r_average    <= 1'b0;
            r_chroma     <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_upper_left <= '0;
            r_line_vld   <= '0;
            r_above_vld  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_HALF_X:  r_half_x  <= i_cfg_data;
                    CFG_HALF_Y:  r_half_y  <= i_cfg_data;
                    CFG_AVERAGE: r_average <= i_cfg_data;
                    CFG_CHROMA:  r_chroma  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col       <= n_col;
            r_row       <= n_row;
            r_above_vld <= r_line_vld[n_col];
            if (w_accept) begin
                r_left            <= w_src;
                r_upper_left      <= w_above;
                r_line_vld[r_col] <= 1'b1;
            end
            if (w_accept && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line buffer: written at the current column, read one column ahead.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_line_mem[r_col] <= w_src;
        end
        r_above_raw <= r_line_mem[n_col];
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_pixel <= w_pred;
            r_out_last  <= w_end_col && w_end_row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tlast  = r_out_last;

`include "halfpel_motion_compensation_assert.svh"

    // The column never leaves the line buffer.
    `HPMC_ASSERT_IMP(a_col_range, 1'b1, r_col < COL_W'(ROW_DEPTH))
    // A pixel that completes an output position yields a word next cycle.
    `HPMC_ASSERT_NEXT(a_emit_out, w_accept && w_emit, m_axis_tvalid)
    // The final pixel of the window returns the position to the origin.
    `HPMC_ASSERT_NEXT(a_wrap, w_accept && w_end_col && w_end_row, r_col == '0 && r_row == '0)

endmodule
